// ===== rtl/sao_pkg.sv =====
// Types, angle constants and wrap helpers for the swerve angle optimizer.
// Depends on nothing; used by swerve_angle_optimizer_unit.
package sao_pkg;

   localparam int ANGLE_FRAC_BITS = 4;
   localparam int TURN            = 360 << ANGLE_FRAC_BITS;
   localparam int HALF_TURN       = 180 << ANGLE_FRAC_BITS;
   localparam int QUARTER_TURN    = 90 << ANGLE_FRAC_BITS;

   localparam int TARGET_W = 13;
   localparam int ADJ_W    = 14;
   localparam int DIFF_W   = 15;
   localparam int FMOD_W   = 13;

   typedef logic signed [TARGET_W-1:0] target_type;
   typedef logic signed [ADJ_W-1:0]    adj_type;
   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic        [FMOD_W-1:0]   fmod_type;
   typedef logic        [FMOD_W:0]     fmsum_type;

   localparam adj_type   TURN_A    = adj_type'(TURN);
   localparam diff_type  TURN_D    = diff_type'(TURN);
   localparam diff_type  HALF_D    = diff_type'(HALF_TURN);
   localparam diff_type  QUARTER_D = diff_type'(QUARTER_TURN);
   localparam fmsum_type TURN_FS   = fmsum_type'(TURN);

   function automatic diff_type wrap_once(input diff_type a);
      diff_type r;
      if (a > HALF_D) begin
         r = a - TURN_D;
      end else if (a < -HALF_D) begin
         r = a + TURN_D;
      end else begin
         r = a;
      end
      return r;
   endfunction

   function automatic logic in_flip_band(input diff_type a);
      return (a > QUARTER_D && a <= HALF_D) || (a < -QUARTER_D && a >= -HALF_D);
   endfunction

   function automatic diff_type fold_quarter(input diff_type a);
      diff_type r;
      if (a > QUARTER_D && a <= HALF_D) begin
         r = a - HALF_D;
      end else if (a < -QUARTER_D && a >= -HALF_D) begin
         r = a + HALF_D;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

// ===== rtl/swerve_angle_optimizer_unit.sv =====
// Swerve steering angle optimizer: one target heading in, one steering angle and
// drive direction out. Uses sao_pkg for types, constants and wrap helpers.
// Path: a req transfer is captured in the input register, and the result is then
// registered in the result register, which drives rsp_valid.
// Throughput: one target per cycle while rsp_ready does not stall the result register;
// the state loop (angle, floor remainder by a full turn, last targets, direction) is combinational.
// Reset: synchronous, clears both stage valids, angle, remainder, targets and direction; no clearing pass.
module swerve_angle_optimizer_unit #(
   parameter int ANGLE_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [12:0]            req_target_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0] rsp_wheel_angle,
   output logic                          rsp_reversed
);

   typedef logic signed [ANGLE_WIDTH-1:0] acc_type;
   typedef logic signed [ANGLE_WIDTH:0]   sum_type;

   localparam longint AccMax = (longint'(1) <<< (ANGLE_WIDTH - 1)) - 1;
   localparam longint TurnL  = longint'(sao_pkg::TURN);
   localparam sao_pkg::fmod_type HiFmod = sao_pkg::fmod_type'(AccMax % TurnL);
   localparam sao_pkg::fmod_type LoFmod =
      sao_pkg::fmod_type'((TurnL - ((AccMax + 1) % TurnL)) % TurnL);
   localparam acc_type AccHi = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
   localparam acc_type AccLo = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};

   logic                 in_valid_ff;
   sao_pkg::target_type  in_target_ff;
   acc_type              steer_ff;
   sao_pkg::fmod_type    fmod_ff;
   sao_pkg::target_type  last_target_ff;
   sao_pkg::adj_type     last_adj_ff;
   logic                 rev_ff;
   logic                 rsp_valid_ff;
   acc_type              rsp_angle_ff;
   logic                 rsp_rev_ff;

   logic                 advance;
   logic                 changed;
   logic                 steer_neg;
   logic                 t_neg;
   logic                 t_pos;
   sao_pkg::adj_type     m_old;
   sao_pkg::adj_type     adj_base;
   sao_pkg::adj_type     adj;
   sao_pkg::diff_type    d_wrap;
   logic                 toggle;
   sao_pkg::diff_type    step;
   sum_type              sum;
   logic                 ovf;
   acc_type              na;
   sao_pkg::diff_type    step_pos;
   sao_pkg::fmsum_type   fm_sum;
   sao_pkg::fmsum_type   fm_red;
   sao_pkg::fmod_type    fm_new;
   sao_pkg::adj_type     m_new;
   logic                 rev_new;

   acc_type              steer_in;
   sao_pkg::fmod_type    fmod_in;
   sao_pkg::target_type  last_target_in;
   sao_pkg::adj_type     last_adj_in;
   logic                 rev_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_wheel_angle = rsp_angle_ff;
   assign rsp_reversed    = rsp_rev_ff;

   always_comb begin
      changed   = in_target_ff != last_target_ff;
      steer_neg = steer_ff[ANGLE_WIDTH-1];
      t_neg     = in_target_ff[sao_pkg::TARGET_W-1];
      t_pos     = !t_neg && (in_target_ff != '0);

      m_old = sao_pkg::adj_type'({1'b0, fmod_ff});
      if (steer_neg && fmod_ff != '0) begin
         m_old = m_old - sao_pkg::TURN_A;
      end

      adj_base = sao_pkg::adj_type'(in_target_ff);
      if (!steer_neg && t_neg) begin
         adj = adj_base + sao_pkg::TURN_A;
      end else if (steer_neg && t_pos) begin
         adj = adj_base - sao_pkg::TURN_A;
      end else begin
         adj = adj_base;
      end

      d_wrap = sao_pkg::wrap_once(sao_pkg::diff_type'(adj) - sao_pkg::diff_type'(last_adj_ff));
      toggle = sao_pkg::in_flip_band(d_wrap);

      step = sao_pkg::fold_quarter(
         sao_pkg::wrap_once(sao_pkg::diff_type'(adj) - sao_pkg::diff_type'(m_old)));

      sum = sum_type'(steer_ff) + sum_type'(step);
      ovf = sum[ANGLE_WIDTH] != sum[ANGLE_WIDTH-1];
      if (ovf) begin
         na = sum[ANGLE_WIDTH] ? AccLo : AccHi;
      end else begin
         na = sum[ANGLE_WIDTH-1:0];
      end

      // track the floor remainder by a full turn alongside the angle
      step_pos = step[sao_pkg::DIFF_W-1] ? (step + sao_pkg::TURN_D) : step;
      fm_sum   = sao_pkg::fmsum_type'({1'b0, fmod_ff}) + step_pos[sao_pkg::FMOD_W:0];
      fm_red   = (fm_sum >= sao_pkg::TURN_FS) ? (fm_sum - sao_pkg::TURN_FS) : fm_sum;
      if (ovf) begin
         fm_new = sum[ANGLE_WIDTH] ? LoFmod : HiFmod;
      end else begin
         fm_new = fm_red[sao_pkg::FMOD_W-1:0];
      end

      m_new = sao_pkg::adj_type'({1'b0, fm_new});
      if (na[ANGLE_WIDTH-1] && fm_new != '0) begin
         m_new = m_new - sao_pkg::TURN_A;
      end

      rev_new = (adj == m_new) ? 1'b0 : (rev_ff ^ toggle);

      if (changed) begin
         steer_in       = na;
         fmod_in        = fm_new;
         last_target_in = in_target_ff;
         last_adj_in    = adj;
         rev_in         = rev_new;
      end else begin
         steer_in       = steer_ff;
         fmod_in        = fmod_ff;
         last_target_in = last_target_ff;
         last_adj_in    = last_adj_ff;
         rev_in         = rev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         steer_ff       <= '0;
         fmod_ff        <= '0;
         last_target_ff <= '0;
         last_adj_ff    <= '0;
         rev_ff         <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (req_valid && req_ready) begin
            in_target_ff <= req_target_angle;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            rsp_angle_ff   <= steer_in;
            rsp_rev_ff     <= rev_in;
            steer_ff       <= steer_in;
            fmod_ff        <= fmod_in;
            last_target_ff <= last_target_in;
            last_adj_ff    <= last_adj_in;
            rev_ff         <= rev_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_fmod_range: assert property (@(posedge clock) disable iff (reset)
      fmod_ff < sao_pkg::fmod_type'(sao_pkg::TURN))
      else $error("turn remainder out of range");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_angle_ff == steer_ff && rsp_rev_ff == rev_ff))
      else $error("result register disagrees with steering state");

   a_repeat_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && !changed) |=> (steer_ff == $past(steer_ff) && rev_ff == $past(rev_ff)))
      else $error("repeated target changed the state");

   a_adj_range: assert property (@(posedge clock) disable iff (reset)
      (last_adj_ff < sao_pkg::TURN_A) && (last_adj_ff > -sao_pkg::TURN_A))
      else $error("adjusted target beyond a full turn");

endmodule

// ===== verif/sao_wheel_checker.sv =====
// Transfer checker for swerve_angle_optimizer_unit: predicts wheel angle and direction
// per target transfer and compares them with every result transfer, in order.
// Depends on sao_pkg for the target type and the turn constants.
module sao_wheel_checker #(
   parameter int ANGLE_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  sao_pkg::target_type           req_target_angle,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [ANGLE_WIDTH-1:0] rsp_wheel_angle,
   input  logic                          rsp_reversed,
   output int                            errors,
   output int                            outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [ANGLE_WIDTH-1:0] angle;
      logic                          reversed;
   } wheel_cmd_type;

   wheel_cmd_type                 pending_wheel_cmds[$];
   logic signed [ANGLE_WIDTH-1:0] steer;
   sao_pkg::target_type           last_tgt;
   sao_pkg::adj_type              last_adj;
   logic                          drive_rev;

   function automatic longint turn_rem(input longint a);
      return a - (a / sao_pkg::TURN) * sao_pkg::TURN;
   endfunction

   function automatic longint to_half_turn(input longint a);
      longint r;
      r = a;
      if (a > sao_pkg::HALF_TURN) begin
         r = a - sao_pkg::TURN;
      end else if (a < -sao_pkg::HALF_TURN) begin
         r = a + sao_pkg::TURN;
      end
      return r;
   endfunction

   function automatic logic past_quarter(input longint a);
      return (a > sao_pkg::QUARTER_TURN && a <= sao_pkg::HALF_TURN) ||
             (a < -sao_pkg::QUARTER_TURN && a >= -sao_pkg::HALF_TURN);
   endfunction

   task automatic steer_to_target(input sao_pkg::target_type t, output wheel_cmd_type cmd);
      longint adj;
      longint delta;
      longint step;
      longint sum;
      longint hi;
      longint lo;
      if (t != last_tgt) begin
         adj = t;
         if (steer >= 0 && t < 0) begin
            adj = adj + sao_pkg::TURN;
         end else if (steer < 0 && t > 0) begin
            adj = adj - sao_pkg::TURN;
         end
         delta = to_half_turn(adj - last_adj);
         if (past_quarter(delta)) begin
            drive_rev = !drive_rev;
         end
         step = to_half_turn(adj - turn_rem(steer));
         if (step > sao_pkg::QUARTER_TURN && step <= sao_pkg::HALF_TURN) begin
            step = step - sao_pkg::HALF_TURN;
         end else if (step < -sao_pkg::QUARTER_TURN && step >= -sao_pkg::HALF_TURN) begin
            step = step + sao_pkg::HALF_TURN;
         end
         last_tgt = t;
         last_adj = sao_pkg::adj_type'(adj);
         hi = (longint'(1) << (ANGLE_WIDTH - 1)) - 1;
         lo = -hi - 1;
         sum = steer + step;
         if (sum > hi) begin
            sum = hi;
         end
         if (sum < lo) begin
            sum = lo;
         end
         steer = sum[ANGLE_WIDTH-1:0];
         if (adj == turn_rem(steer)) begin
            drive_rev = 1'b0;
         end
      end
      cmd.angle    = steer;
      cmd.reversed = drive_rev;
   endtask

   always @(posedge clock) begin
      wheel_cmd_type want;
      wheel_cmd_type next_cmd;
      if (reset) begin
         steer     = '0;
         last_tgt  = '0;
         last_adj  = '0;
         drive_rev = 1'b0;
         errors    = 0;
         pending_wheel_cmds.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_wheel_cmds.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transfer, expected none, got angle %0d rev %0b",
                        $time, rsp_wheel_angle, rsp_reversed);
            end else begin
               want = pending_wheel_cmds.pop_front();
               if (rsp_wheel_angle !== want.angle) begin
                  errors++;
                  $display("%0t: wheel_angle expected %0d, got %0d",
                           $time, want.angle, rsp_wheel_angle);
               end
               if (rsp_reversed !== want.reversed) begin
                  errors++;
                  $display("%0t: reversed expected %0b, got %0b",
                           $time, want.reversed, rsp_reversed);
               end
            end
         end
         if (req_valid && req_ready) begin
            steer_to_target(req_target_angle, next_cmd);
            pending_wheel_cmds.push_back(next_cmd);
         end
      end
      outstanding = pending_wheel_cmds.size();
   end

endmodule

// ===== verif/swerve_angle_optimizer_unit_tb.sv =====
// Top of the swerve_angle_optimizer_unit bench: clock, reset, target stimulus,
// result back-pressure and the verdict. Depends on sao_pkg and sao_wheel_checker.
module swerve_angle_optimizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_WIDTH  = 24;
   localparam int RANDOM_ITEMS = 420;
   localparam int SWEEP_STEP   = 1280;
   localparam int SWEEP_UP     = 60;
   localparam int SWEEP_DOWN   = 100;
   localparam int DIRECTED [22] = '{0, 0, 2880, 2880, -2880, -1440, -1440, 1439, 1441,
                                    -2879, 2879, 4095, -4096, 4095, -4096, 1, -1,
                                    2881, -2881, 1000, 0, -1000};
   localparam int NEAR_STEPS [12] = '{1440, -1440, 1439, -1439, 1441, -1441,
                                      2880, -2880, 2879, -2879, 2881, -2881};
   localparam int EDGE_VALUES [6] = '{-4096, 4095, -2880, 2880, 0, -1};

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   typedef enum int {
      PICK_NOMINAL,
      PICK_FULL,
      PICK_REPEAT,
      PICK_NEAR,
      PICK_EDGE
   } pick_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   sao_pkg::target_type           req_target_angle = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [ANGLE_WIDTH-1:0] rsp_wheel_angle;
   logic                          rsp_reversed;
   int                            errors;
   int                            outstanding;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   int             burst_left = 0;

   swerve_angle_optimizer_unit #(.ANGLE_WIDTH(ANGLE_WIDTH)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_angle (req_target_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wheel_angle  (rsp_wheel_angle),
      .rsp_reversed     (rsp_reversed)
   );

   sao_wheel_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) wheel_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_angle (req_target_angle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_wheel_angle  (rsp_wheel_angle),
      .rsp_reversed     (rsp_reversed),
      .errors           (errors),
      .outstanding      (outstanding)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(20, 80);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end
         READY_SPARSE: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= mode_left[2];
         end
      endcase
   end

   task automatic send_target(input sao_pkg::target_type t);
      req_target_angle <= t;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin
      sao_pkg::target_type last;
      int                  heading;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         send_target(sao_pkg::target_type'(DIRECTED[i]));
      end
      drain_results();

      last = sao_pkg::target_type'(DIRECTED[$size(DIRECTED) - 1]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case (pick_type'($urandom_range(0, 4)))
            PICK_NOMINAL: begin
               last = sao_pkg::target_type'(int'($urandom_range(0, 5760)) - 2880);
            end
            PICK_FULL: begin
               last = sao_pkg::target_type'($urandom);
            end
            PICK_REPEAT: begin
               last = last;
            end
            PICK_NEAR: begin
               last = sao_pkg::target_type'(int'(last) + NEAR_STEPS[$urandom_range(0, 11)]);
            end
            default: begin
               last = sao_pkg::target_type'(EDGE_VALUES[$urandom_range(0, 5)]);
            end
         endcase
         send_target(last);
         if (n == RANDOM_ITEMS / 2) begin
            drain_results();
         end
      end

      heading = 0;
      for (int n = 0; n < SWEEP_UP; n++) begin
         heading = heading + SWEEP_STEP;
         if (heading > 2880) begin
            heading = heading - 5760;
         end
         send_target(sao_pkg::target_type'(heading));
      end
      for (int n = 0; n < SWEEP_DOWN; n++) begin
         heading = heading - SWEEP_STEP;
         if (heading <= -2880) begin
            heading = heading + 5760;
         end
         send_target(sao_pkg::target_type'(heading));
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
